### rtl/ble_packet_rx_checker_top_assert.svh
// ----------------------------------------------------------------------------
// BLE packet receive checker assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef BLE_PACKET_RX_CHECKER_TOP_ASSERT_SVH
`define BLE_PACKET_RX_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds on every clock edge outside reset
`define BPRC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bprc assertion failed");

// Antecedent implies consequent in the same cycle
`define BPRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bprc implication failed");

// Antecedent implies consequent in the next cycle
`define BPRC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bprc next-cycle implication failed");

`else

`define BPRC_ASSERT(label, clk, rst, prop)
`define BPRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPRC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/bprc_pkg.sv
// ----------------------------------------------------------------------------
// BLE packet receive checker package
// Shared widths, codes, config and beat types, and the CRC-24 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package bprc_pkg;

   localparam int BYTE_W    = 8;
   localparam int CHAN_W    = 6;
   localparam int ADDR_W    = 32;
   localparam int CRC_W     = 24;
   localparam int LEN_W     = 9;
   localparam int POS_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int STATUS_W  = 2;

   // Register reset values
   localparam logic [CHAN_W-1:0] RF_CHANNEL_RST     = 6'd0;
   localparam logic [ADDR_W-1:0] ACCESS_ADDRESS_RST = 32'h8E89BED6;
   localparam logic [CRC_W-1:0]  CRC_INIT_RST       = 24'h555555;
   localparam logic [LEN_W-1:0]  RX_LIMIT_RST       = 9'd257;

   // CRC-24, reflected form
   localparam logic [CRC_W-1:0] CRC_TAPS = 24'h5A6000;
   localparam logic [CRC_W-1:0] CRC_TOP  = 24'h800000;

   // Frame layout
   localparam logic [POS_W-1:0] PDU_START = 9'd5;
   localparam logic [POS_W-1:0] POS_MAX   = 9'd511;
   localparam logic [LEN_W-1:0] HDR_LEN   = 9'd2;
   localparam logic [LEN_W-1:0] CRC_BYTES = 9'd3;
   localparam logic [POS_W:0]   MIN_FRAME = 10'd10;
   localparam logic [POS_W:0]   FRAME_OVH = 10'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RF_CHANNEL     = 2'd0,
      CSR_ACCESS_ADDRESS = 2'd1,
      CSR_CRC_INIT       = 2'd2,
      CSR_RX_LIMIT       = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC_ERR  = 2'd1,
      STATUS_TOO_LONG = 2'd2,
      STATUS_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [CHAN_W-1:0] rf_channel;
      logic [ADDR_W-1:0] access_address;
      logic [CRC_W-1:0]  crc_init;
      logic [LEN_W-1:0]  rx_limit;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pdu_byte;
      logic              pdu_valid;
      logic              frame_done;
      status_type        status;
   } rsp_beat_type;

   // Advance the CRC by one byte, LSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0]  c;
      logic [BYTE_W-1:0] d;
      logic              fb;
      c = crc;
      d = data;
      for (int k = 0; k < BYTE_W; k++) begin
         fb = c[0] ^ d[0];
         d  = d >> 1;
         c  = c >> 1;
         if (fb) begin
            c = (c | CRC_TOP) ^ CRC_TAPS;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/bprc_ifs.sv
// ----------------------------------------------------------------------------
// BLE packet receive checker channels
// Valid/ready channel bundles for the received bytes and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface bprc_req_if;
   logic                        valid;
   logic                        ready;
   logic [bprc_pkg::BYTE_W-1:0] rx_byte;
   logic                        frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface bprc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bprc_pkg::BYTE_W-1:0]   pdu_byte;
   logic                          pdu_valid;
   logic                          frame_done;
   logic [bprc_pkg::STATUS_W-1:0] status;

   modport source (output valid, output pdu_byte, output pdu_valid, output frame_done,
                   output status, input ready);
   modport sink   (input valid, input pdu_byte, input pdu_valid, input frame_done,
                   input status, output ready);
endinterface

`default_nettype wire

### rtl/bprc_csr.sv
// ----------------------------------------------------------------------------
// BLE packet receive checker configuration registers
// Write-only register file for channel, access address, CRC init and limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bprc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [bprc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bprc_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output      bprc_pkg::cfg_type                cfg
);
   import bprc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RF_CHANNEL:     cfg_in.rf_channel     = csr_wdata[CHAN_W-1:0];
            CSR_ACCESS_ADDRESS: cfg_in.access_address = csr_wdata[ADDR_W-1:0];
            CSR_CRC_INIT:       cfg_in.crc_init       = csr_wdata[CRC_W-1:0];
            CSR_RX_LIMIT:       cfg_in.rx_limit       = csr_wdata[LEN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rf_channel     <= RF_CHANNEL_RST;
         cfg_ff.access_address <= ACCESS_ADDRESS_RST;
         cfg_ff.crc_init       <= CRC_INIT_RST;
         cfg_ff.rx_limit       <= RX_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/bprc_frame.sv
// ----------------------------------------------------------------------------
// BLE packet receive checker frame tracker
// Per-byte frame parsing, header match, CRC-24 update and final status.
// ----------------------------------------------------------------------------
`default_nettype none

module bprc_frame (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [bprc_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic                          frame_end,
   input  wire bprc_pkg::cfg_type             cfg,
   output      bprc_pkg::rsp_beat_type        beat
);
   import bprc_pkg::*;

   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [CRC_W-1:0] crc_ff,  crc_in;
   logic [LEN_W-1:0] len_ff,  len_in;
   logic [CRC_W-1:0] rcrc_ff, rcrc_in;
   logic             mis_ff,  mis_in;

   logic [CRC_W-1:0]  crc_n;
   logic [LEN_W-1:0]  len_n;
   logic [CRC_W-1:0]  rcrc_n;
   logic              mis_n;
   logic              in_pdu;
   logic [POS_W-1:0]  off;
   logic [POS_W-1:0]  rel;
   logic [BYTE_W-1:0] want;
   logic [POS_W:0]    count;
   status_type        status;

   assign off   = pos_ff - PDU_START;
   assign rel   = off - len_ff;
   assign count = {1'b0, pos_ff} + 10'd1;

   // Pick the expected access-address byte, least significant first
   always_comb begin
      case (pos_ff[2:0])
         3'd1:    want = cfg.access_address[7:0];
         3'd2:    want = cfg.access_address[15:8];
         3'd3:    want = cfg.access_address[23:16];
         3'd4:    want = cfg.access_address[31:24];
         default: want = '0;
      endcase
   end

   // Parse the byte at its frame position
   always_comb begin
      crc_n  = crc_ff;
      len_n  = len_ff;
      rcrc_n = rcrc_ff;
      mis_n  = mis_ff;
      in_pdu = 1'b0;
      if (pos_ff == '0) begin
         crc_n = cfg.crc_init;
         if (rx_byte != {2'b00, cfg.rf_channel}) begin
            mis_n = 1'b1;
         end
      end else if (pos_ff < PDU_START) begin
         if (rx_byte != want) begin
            mis_n = 1'b1;
         end
      end else if (off < len_ff) begin
         in_pdu = 1'b1;
         crc_n  = crc_byte(crc_ff, rx_byte);
         if (off == 9'd1) begin
            len_n = HDR_LEN + {1'b0, rx_byte};
         end
      end else if (rel < CRC_BYTES) begin
         case (rel[1:0])
            2'd0:    rcrc_n[7:0]   = rcrc_ff[7:0]   | rx_byte;
            2'd1:    rcrc_n[15:8]  = rcrc_ff[15:8]  | rx_byte;
            default: rcrc_n[23:16] = rcrc_ff[23:16] | rx_byte;
         endcase
      end
   end

   // Grade the frame on its final byte
   always_comb begin
      if (count < MIN_FRAME || mis_n) begin
         status = STATUS_IGNORED;
      end else if (len_n > cfg.rx_limit) begin
         status = STATUS_TOO_LONG;
      end else if (count < ({1'b0, len_n} + FRAME_OVH) || rcrc_n != crc_n) begin
         status = STATUS_CRC_ERR;
      end else begin
         status = STATUS_OK;
      end
   end

   // Rearm on the final byte, otherwise advance with saturation
   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      len_in  = len_ff;
      rcrc_in = rcrc_ff;
      mis_in  = mis_ff;
      if (step) begin
         if (frame_end) begin
            pos_in  = '0;
            crc_in  = cfg.crc_init;
            len_in  = HDR_LEN;
            rcrc_in = '0;
            mis_in  = 1'b0;
         end else begin
            pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 9'd1;
            crc_in  = crc_n;
            len_in  = len_n;
            rcrc_in = rcrc_n;
            mis_in  = mis_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         crc_ff  <= CRC_INIT_RST;
         len_ff  <= HDR_LEN;
         rcrc_ff <= '0;
         mis_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         len_ff  <= len_in;
         rcrc_ff <= rcrc_in;
         mis_ff  <= mis_in;
      end
   end

   // Build the result beat
   always_comb begin
      beat.pdu_byte   = in_pdu ? rx_byte : '0;
      beat.pdu_valid  = in_pdu;
      beat.frame_done = frame_end;
      beat.status     = frame_end ? status : STATUS_OK;
   end

endmodule

`default_nettype wire

### rtl/ble_packet_rx_checker_top.sv
// ----------------------------------------------------------------------------
// BLE packet receive checker
// Checks a received BLE frame byte by byte and grades it on its last byte.
//
// Each accepted byte yields exactly one result beat. A byte is taken into an
// input register and parsed against the frame state (channel, access address,
// PDU with an unrolled 8-bit CRC-24 step, received CRC). The beat lands in an
// output register when the frame tracker steps, which waits while a beat in the
// output register is not taken. The block sustains one byte per cycle while the
// result channel is ready; the CRC byte update in the frame tracker is
// combinational. PDU bytes are flagged with pdu_valid even for frames that later
// grade as ignored, so the user drops them on that status. Configuration is
// written through the csr port while no beat is in flight; crc_init takes effect
// at the next channel byte. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ble_packet_rx_checker_top_assert.svh"

module ble_packet_rx_checker_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bprc_req_if.sink                              req_if,
   bprc_rsp_if.source                            rsp_if,
   input  wire logic                             csr_we,
   input  wire logic [bprc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bprc_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import bprc_pkg::*;

   cfg_type           cfg;
   rsp_beat_type      beat;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   logic              in_end_ff,   in_end_in;
   logic              out_valid_ff, out_valid_in;
   rsp_beat_type      out_ff, out_in;

   logic              out_free;
   logic              advance;
   logic              req_take;

   // Handshake: the output register frees the input stage
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_if.ready  = !in_valid_ff || out_free;
   assign req_take      = req_if.valid && req_if.ready;

   bprc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bprc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .frame_end (in_end_ff),
      .cfg       (cfg),
      .beat      (beat)
   );

   // Load the input register on each accepted beat
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.rx_byte;
         in_end_in   = req_if.frame_end;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Load the output register as the frame tracker steps; drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = beat;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      out_ff     <= out_in;
   end

   // Drive the result channel
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.pdu_byte   = out_ff.pdu_byte;
   assign rsp_if.pdu_valid  = out_ff.pdu_valid;
   assign rsp_if.frame_done = out_ff.frame_done;
   assign rsp_if.status     = out_ff.status;

   // A stalled output with a pending input byte blocks new bytes
   `BPRC_ASSERT_IMP(a_stall_blocks_input, clock, reset,
                    in_valid_ff && out_valid_ff && !rsp_if.ready, !req_if.ready)
   // A final byte that steps shows up next cycle as a done beat
   `BPRC_ASSERT_NXT(a_end_gives_done, clock, reset,
                    advance && in_end_ff, out_valid_ff && out_ff.frame_done)
   // Status is only graded on the final byte
   `BPRC_ASSERT_IMP(a_status_on_done, clock, reset,
                    out_valid_ff && !out_ff.frame_done, out_ff.status == STATUS_OK)

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// BLE packet receive checker testbench
// Feeds received frames one byte at a time through the request channel and
// grades every result beat against a cycle-free model of the byte parser,
// CRC-24 and frame grading. A short table of hand-checked bytes comes first,
// then randomized well-formed and damaged frames under several register sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bprc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SHOW_LIMIT  = 10;

   typedef enum logic [1:0] {
      FILL_NONE,
      FILL_CRC_LO,
      FILL_CRC_MID,
      FILL_CRC_HI
   } fill_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      fill_kind_type     fill;
      logic              pinned;
      rsp_beat_type      beat;
   } opening_row_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CHANNEL,
      FRAME_BAD_ADDRESS,
      FRAME_BAD_CRC,
      FRAME_CUT,
      FRAME_TRAILING,
      FRAME_NOISE,
      FRAME_OVERRUN
   } frame_kind_type;

   localparam rsp_beat_type NO_PDU = '{8'h00, 1'b0, 1'b0, STATUS_OK};

   // Hand-checked opening bytes: a lone channel byte, a minimal good frame
   // under the reset registers, and a frame that stops one CRC byte short.
   localparam opening_row_type OPENING [21] = '{
      '{8'h00, 1'b1, FILL_NONE,    1'b1, '{8'h00, 1'b0, 1'b1, STATUS_IGNORED}},
      '{8'h00, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'hD6, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'hBE, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'h89, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'h8E, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'hFF, 1'b0, FILL_NONE,    1'b1, '{8'hFF, 1'b1, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, FILL_NONE,    1'b1, '{8'h00, 1'b1, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, FILL_CRC_LO,  1'b1, NO_PDU},
      '{8'h00, 1'b0, FILL_CRC_MID, 1'b1, NO_PDU},
      '{8'h00, 1'b1, FILL_CRC_HI,  1'b1, '{8'h00, 1'b0, 1'b1, STATUS_OK}},
      '{8'h00, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'hD6, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'hBE, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'h89, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'h8E, 1'b0, FILL_NONE,    1'b1, NO_PDU},
      '{8'h12, 1'b0, FILL_NONE,    1'b1, '{8'h12, 1'b1, 1'b0, STATUS_OK}},
      '{8'h01, 1'b0, FILL_NONE,    1'b1, '{8'h01, 1'b1, 1'b0, STATUS_OK}},
      '{8'hAB, 1'b0, FILL_NONE,    1'b1, '{8'hAB, 1'b1, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, FILL_CRC_LO,  1'b0, NO_PDU},
      '{8'h00, 1'b1, FILL_CRC_MID, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_CRC_ERR}}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   bprc_req_if req_ch ();
   bprc_rsp_if rsp_ch ();

   // Per-beat override for hand-checked rows
   logic         pin_on;
   rsp_beat_type pin_beat;
   logic         steady;

   // Frame model state and register shadow
   cfg_type      shadow_cfg;
   int           rx_pos;
   logic [23:0]  run_crc;
   int           pdu_len;
   logic [23:0]  got_crc;
   logic         hdr_bad;

   rsp_beat_type graded_beats [$];
   int           mismatches;
   int           beats_checked;
   int           bytes_sent;
   int           frames_sent;
   int           status_tally [4];

   ble_packet_rx_checker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the CRC-24 by one byte, least significant bit first
   function automatic logic [23:0] crc24_step(input logic [23:0] state,
                                              input logic [7:0] data);
      logic [23:0] s;
      s = state;
      for (int i = 0; i < 8; i++) begin
         if (s[0] ^ data[i]) begin
            s = {1'b1, s[23:1]} ^ CRC_TAPS;
         end else begin
            s = {1'b0, s[23:1]};
         end
      end
      return s;
   endfunction

   function automatic void rearm_frame();
      rx_pos  = 0;
      run_crc = shadow_cfg.crc_init;
      pdu_len = 2;
      got_crc = '0;
      hdr_bad = 1'b0;
   endfunction

   // Parse one frame byte and return the beat it should produce
   function automatic rsp_beat_type grade_byte(input logic [7:0] b, input logic last);
      rsp_beat_type beat;
      int           off;
      int           count;
      beat = NO_PDU;
      if (rx_pos == 0) begin
         run_crc = shadow_cfg.crc_init;
         if (b != {2'b00, shadow_cfg.rf_channel}) hdr_bad = 1'b1;
      end else if (rx_pos < 5) begin
         if (b != shadow_cfg.access_address[8*(rx_pos-1) +: 8]) hdr_bad = 1'b1;
      end else begin
         off = rx_pos - 5;
         if (off < pdu_len) begin
            beat.pdu_valid = 1'b1;
            beat.pdu_byte  = b;
            run_crc = crc24_step(run_crc, b);
            if (off == 1) pdu_len = 2 + b;
         end else if (off - pdu_len < 3) begin
            got_crc[8*(off-pdu_len) +: 8] = b;
         end
      end

      if (last) begin
         count = rx_pos + 1;
         beat.frame_done = 1'b1;
         if (count < 10 || hdr_bad) beat.status = STATUS_IGNORED;
         else if (pdu_len > shadow_cfg.rx_limit) beat.status = STATUS_TOO_LONG;
         else if (count < pdu_len + 8 || got_crc != run_crc) beat.status = STATUS_CRC_ERR;
         else beat.status = STATUS_OK;
         rearm_frame();
      end else if (rx_pos < 511) begin
         rx_pos++;
      end
      return beat;
   endfunction

   // Track register writes, grade accepted bytes, check result beats
   always @(posedge clock) begin : scoreboard
      rsp_beat_type want;
      rsp_beat_type got;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_RF_CHANNEL:     shadow_cfg.rf_channel     = csr_wdata[CHAN_W-1:0];
               CSR_ACCESS_ADDRESS: shadow_cfg.access_address = csr_wdata[ADDR_W-1:0];
               CSR_CRC_INIT:       shadow_cfg.crc_init       = csr_wdata[CRC_W-1:0];
               CSR_RX_LIMIT:       shadow_cfg.rx_limit       = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            want = grade_byte(req_ch.rx_byte, req_ch.frame_end);
            graded_beats.push_back(pin_on ? pin_beat : want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.pdu_byte, rsp_ch.pdu_valid, rsp_ch.frame_done,
                    status_type'(rsp_ch.status)};
            if (graded_beats.size() == 0) begin
               if (mismatches < SHOW_LIMIT)
                  $display("tb: beat %0d arrived with nothing outstanding", beats_checked);
               mismatches++;
            end else begin
               want = graded_beats.pop_front();
               if (got.pdu_byte !== want.pdu_byte || got.pdu_valid !== want.pdu_valid ||
                   got.frame_done !== want.frame_done || got.status !== want.status) begin
                  if (mismatches < SHOW_LIMIT)
                     $display({"tb: beat %0d: want byte %h valid %b done %b status %0d,",
                               " got byte %h valid %b done %b status %0d"},
                              beats_checked, want.pdu_byte, want.pdu_valid,
                              want.frame_done, want.status, got.pdu_byte,
                              got.pdu_valid, got.frame_done, got.status);
                  mismatches++;
               end
               if (got.frame_done === 1'b1) status_tally[got.status]++;
            end
            beats_checked++;
         end
      end
   end

   // End the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // Random backpressure on the result channel
   initial begin : result_backpressure
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= 33);
      end
   end

   // Offer one byte, idling at random first; return at the falling edge after
   // the beat was taken
   task automatic send_byte(input logic [7:0] data, input logic last,
                            input logic pinned, input rsp_beat_type beat);
      while (!steady && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= data;
      req_ch.frame_end <= last;
      pin_on           <= pinned;
      pin_beat         <= beat;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Build a frame from the current registers, damage it as asked, send it
   task automatic send_frame(input frame_kind_type kind);
      logic [7:0]  bytes [$];
      logic [7:0]  chan;
      logic [7:0]  x;
      logic [23:0] crc;
      int          len;
      int          idx;
      int          n;
      chan = {2'b00, shadow_cfg.rf_channel};
      len  = ($urandom_range(99) < 8) ? $urandom_range(255) : $urandom_range(24);
      bytes.push_back(chan);
      for (int i = 0; i < 4; i++) bytes.push_back(shadow_cfg.access_address[8*i +: 8]);
      crc = shadow_cfg.crc_init;
      x = 8'($urandom_range(255));
      bytes.push_back(x);
      crc = crc24_step(crc, x);
      bytes.push_back(len[7:0]);
      crc = crc24_step(crc, len[7:0]);
      for (int i = 0; i < len; i++) begin
         x = 8'($urandom_range(255));
         bytes.push_back(x);
         crc = crc24_step(crc, x);
      end
      bytes.push_back(crc[7:0]);
      bytes.push_back(crc[15:8]);
      bytes.push_back(crc[23:16]);

      case (kind)
         FRAME_BAD_CHANNEL: begin
            do x = 8'($urandom_range(255)); while (x == chan);
            bytes[0] = x;
         end
         FRAME_BAD_ADDRESS: begin
            idx = $urandom_range(4, 1);
            bytes[idx] ^= 8'd1 << $urandom_range(7);
         end
         FRAME_BAD_CRC: begin
            idx = $urandom_range(bytes.size() - 1, 5);
            bytes[idx] ^= 8'd1 << $urandom_range(7);
         end
         FRAME_CUT: begin
            n = $urandom_range(bytes.size() - 1, 1);
            repeat (n) void'(bytes.pop_back());
         end
         FRAME_TRAILING: begin
            repeat ($urandom_range(6, 1)) bytes.push_back(8'($urandom_range(255)));
         end
         FRAME_NOISE: begin
            bytes.delete();
            repeat ($urandom_range(40, 1)) bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) bytes[0] = chan;
         end
         FRAME_OVERRUN: begin
            // push the position counter into saturation
            while (bytes.size() < 520) bytes.push_back(8'($urandom_range(255)));
         end
         default: ;
      endcase

      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, 1'b0, NO_PDU);
      frames_sent++;
   endtask

   // Hold the input idle until every beat has come back
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (graded_beats.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings(input logic [CHAN_W-1:0] chan, input logic [ADDR_W-1:0] addr,
                                input logic [CRC_W-1:0] init, input logic [LEN_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_RF_CHANNEL;
      csr_wdata <= CSR_DAT_W'(chan);
      @(negedge clock);
      csr_index <= CSR_ACCESS_ADDRESS;
      csr_wdata <= addr;
      @(negedge clock);
      csr_index <= CSR_CRC_INIT;
      csr_wdata <= CSR_DAT_W'(init);
      @(negedge clock);
      csr_index <= CSR_RX_LIMIT;
      csr_wdata <= CSR_DAT_W'(limit);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One frame of every kind (the overrun kind only when asked), then mostly good frames until the budget is spent
   task automatic run_phase(input int budget, input bit with_overrun);
      int start;
      int r;
      start = bytes_sent;
      for (int k = FRAME_GOOD; k <= FRAME_NOISE; k++) send_frame(frame_kind_type'(k));
      if (with_overrun) send_frame(FRAME_OVERRUN);
      while (bytes_sent - start < budget) begin
         r = $urandom_range(99);
         if (r < 60)      send_frame(FRAME_GOOD);
         else if (r < 67) send_frame(FRAME_BAD_CHANNEL);
         else if (r < 74) send_frame(FRAME_BAD_ADDRESS);
         else if (r < 82) send_frame(FRAME_BAD_CRC);
         else if (r < 89) send_frame(FRAME_CUT);
         else if (r < 95) send_frame(FRAME_TRAILING);
         else             send_frame(FRAME_NOISE);
      end
   endtask

   initial begin
      logic [7:0] data;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = '0;
      req_ch.frame_end = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_RF_CHANNEL;
      csr_wdata        = '0;
      pin_on           = 1'b0;
      pin_beat         = NO_PDU;
      steady           = 1'b0;
      mismatches       = 0;
      beats_checked    = 0;
      bytes_sent       = 0;
      frames_sent      = 0;
      status_tally     = '{0, 0, 0, 0};
      shadow_cfg       = '{RF_CHANNEL_RST, ACCESS_ADDRESS_RST, CRC_INIT_RST, RX_LIMIT_RST};
      rearm_frame();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the hand-checked table under the reset registers
      foreach (OPENING[i]) begin
         case (OPENING[i].fill)
            FILL_CRC_LO:  data = run_crc[7:0];
            FILL_CRC_MID: data = run_crc[15:8];
            FILL_CRC_HI:  data = run_crc[23:16];
            default:      data = OPENING[i].data;
         endcase
         send_byte(data, OPENING[i].last, OPENING[i].pinned, OPENING[i].beat);
      end

      run_phase(250, 1'b0);

      // All-ones address and CRC init, highest channel, full limit, no idling on either side
      settle();
      load_settings(6'd39, 32'hFFFF_FFFF, 24'hFF_FFFF, 9'd257);
      steady = 1'b1;
      run_phase(250, 1'b0);
      steady = 1'b0;

      // All-zero registers: every graded frame is too long
      settle();
      load_settings(6'd0, 32'h0, 24'h0, 9'd0);
      run_phase(150, 1'b0);

      // Random registers with a tight receive limit
      settle();
      load_settings(CHAN_W'($urandom_range(39)), ADDR_W'($urandom),
                    CRC_W'($urandom_range(24'hFF_FFFF)), LEN_W'($urandom_range(60, 2)));
      run_phase(200, 1'b0);

      // Random registers, full receive limit, one overlong stream
      settle();
      load_settings(CHAN_W'($urandom_range(39)), ADDR_W'($urandom),
                    CRC_W'($urandom_range(24'hFF_FFFF)), 9'd257);
      run_phase(400, 1'b1);

      req_ch.valid <= 1'b0;
      while (graded_beats.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (graded_beats.size() != 0) mismatches++;

      $display("tb: %0d bytes in %0d frames, %0d beats checked, %0d mismatches",
               bytes_sent, frames_sent, beats_checked, mismatches);
      $display("tb: graded ok %0d, crc error %0d, too long %0d, ignored %0d",
               status_tally[STATUS_OK], status_tally[STATUS_CRC_ERR],
               status_tally[STATUS_TOO_LONG], status_tally[STATUS_IGNORED]);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/bprc_pkg.sv
rtl/bprc_ifs.sv
rtl/bprc_csr.sv
rtl/bprc_frame.sv
rtl/ble_packet_rx_checker_top.sv
verif/tb.sv
